@@ rtl/core/lrdc_pkg.sv @@
// Shared types and constants for the log record decoder and checker.
`default_nettype none

package lrdc_pkg;

  // Record header layout (byte positions within the 21-byte header)
  localparam int unsigned HDR_LEN   = 21;
  localparam logic [4:0]  TS_POS    = 5'd4;
  localparam logic [4:0]  FLAGS_POS = 5'd12;
  localparam logic [4:0]  KEY_POS   = 5'd13;
  localparam logic [4:0]  VAL_POS   = 5'd17;
  localparam logic [4:0]  HDR_LAST  = 5'd20;

  // Reflected CRC-32 (zlib)
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Record status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HDR_TRUNC  = 3'd1;
  localparam logic [2:0] ST_ZERO_KEY   = 3'd2;
  localparam logic [2:0] ST_TOMB_VALUE = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd4;
  localparam logic [2:0] ST_BODY_TRUNC = 3'd5;
  localparam logic [2:0] ST_CRC_BAD    = 3'd6;

  // Configuration registers
  localparam int unsigned CFG_AW        = 3;
  localparam int unsigned REG_IDX_LSB   = 2;
  localparam logic        REG_MAX_SIZE  = 1'b0;
  localparam logic        REG_TOMB_MASK = 1'b1;
  localparam logic [31:0] MAX_SIZE_RST  = 32'd16777216;
  localparam logic [7:0]  TOMB_MASK_RST = 8'd1;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [31:0] max_size;
    logic [7:0]  tomb_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [63:0] timestamp;
    logic        tombstone;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [33:0] record_size;
    logic        last;
  } result_t;

  // Up to two results pushed per processed byte
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } resq_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/lrdc_cfg.sv @@
// APB-style configuration registers: size limit and tombstone mask.
`default_nettype none

module lrdc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lrdc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output lrdc_pkg::cfg_t                   cfg
);

  logic [31:0] max_size_r;
  logic [7:0]  tomb_mask_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[lrdc_pkg::REG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r  <= lrdc_pkg::MAX_SIZE_RST;
      tomb_mask_r <= lrdc_pkg::TOMB_MASK_RST;
    end else if (wr_en) begin
      if (reg_sel == lrdc_pkg::REG_TOMB_MASK) begin
        tomb_mask_r <= pwdata[7:0];
      end else begin
        max_size_r <= pwdata;
      end
    end
  end

  // Read back
  always_comb begin
    if (reg_sel == lrdc_pkg::REG_TOMB_MASK) begin
      prdata = {24'd0, tomb_mask_r};
    end else begin
      prdata = max_size_r;
    end
  end

  assign cfg.max_size  = max_size_r;
  assign cfg.tomb_mask = tomb_mask_r;

endmodule

`default_nettype wire

@@ rtl/core/lrdc_parser.sv @@
// Input register, record parse state, header checks and CRC update.
`default_nettype none

module lrdc_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_buffer,
  input  wire lrdc_pkg::cfg_t    cfg,
  input  wire logic              room,
  output lrdc_pkg::resq_wr_t     wr
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ lrdc_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  // Input register
  logic        hold_v_r;
  logic [7:0]  byte_r;
  logic        eob_r;

  // Record state
  phase_t      phase_r,  phase_nxt;
  logic [31:0] pos_r,    pos_nxt;
  logic [31:0] scrc_r,   scrc_nxt;
  logic [63:0] ts_r,     ts_nxt;
  logic [7:0]  flags_r,  flags_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [31:0] val_r,    val_nxt;
  logic [31:0] crc_r,    crc_nxt;

  logic        fire;
  logic [4:0]  hp;
  logic [2:0]  ts_idx;
  logic [1:0]  kv_idx;
  logic [33:0] total;
  logic [32:0] body_len;
  logic [32:0] pos_inc;
  lrdc_pkg::result_t res_hdr;
  lrdc_pkg::result_t res_a;
  lrdc_pkg::result_t res_b;
  logic [1:0]  num;

  assign fire     = hold_v_r && room;
  assign in_ready = !hold_v_r || fire;

  assign hp       = pos_r[4:0];
  assign ts_idx   = hp[2:0] - 3'd4;
  assign kv_idx   = hp[1:0] - 2'd1;
  assign body_len = {1'b0, key_r} + {1'b0, val_r};
  assign pos_inc  = {1'b0, pos_r} + 33'd1;

  // Next state and results for the held byte
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    scrc_nxt  = scrc_r;
    ts_nxt    = ts_r;
    flags_nxt = flags_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    crc_nxt   = crc_r;
    num       = 2'd0;
    res_a     = '0;
    res_b     = '0;

    // Header bytes: clear on first byte, then insert little-endian
    if (phase_r == PH_HEADER) begin
      if (pos_r == '0) begin
        scrc_nxt  = '0;
        ts_nxt    = '0;
        flags_nxt = '0;
        key_nxt   = '0;
        val_nxt   = '0;
        crc_nxt   = lrdc_pkg::CRC_INIT;
      end
      if (hp >= lrdc_pkg::TS_POS) begin
        crc_nxt = crc_byte(crc_nxt, byte_r);
      end
      if (hp < lrdc_pkg::TS_POS) begin
        scrc_nxt[{hp[1:0], 3'b000} +: 8] = byte_r;
      end else if (hp < lrdc_pkg::FLAGS_POS) begin
        ts_nxt[{ts_idx, 3'b000} +: 8] = byte_r;
      end else if (hp == lrdc_pkg::FLAGS_POS) begin
        flags_nxt = byte_r;
      end else if (hp < lrdc_pkg::VAL_POS) begin
        key_nxt[{kv_idx, 3'b000} +: 8] = byte_r;
      end else begin
        val_nxt[{kv_idx, 3'b000} +: 8] = byte_r;
      end
      pos_nxt = pos_r + 32'd1;
    end

    total = 34'(lrdc_pkg::HDR_LEN) + {2'b00, key_nxt} + {2'b00, val_nxt};

    res_hdr              = '0;
    res_hdr.timestamp    = ts_nxt;
    res_hdr.tombstone    = |(flags_nxt & cfg.tomb_mask);
    res_hdr.key_length   = key_nxt;
    res_hdr.value_length = val_nxt;
    res_hdr.record_size  = total;

    case (phase_r)
      PH_HEADER: begin
        if (hp != lrdc_pkg::HDR_LAST) begin
          // Buffer ran out inside the header
          if (eob_r) begin
            num          = 2'd1;
            res_a.kind   = lrdc_pkg::KIND_STATUS;
            res_a.status = lrdc_pkg::ST_HDR_TRUNC;
            pos_nxt      = '0;
          end
        end else begin
          res_a      = res_hdr;
          res_a.kind = lrdc_pkg::KIND_STATUS;
          pos_nxt    = '0;
          // Header checks in priority order
          if (key_nxt == '0) begin
            res_a.status = lrdc_pkg::ST_ZERO_KEY;
          end else if (res_hdr.tombstone && (val_nxt != '0)) begin
            res_a.status = lrdc_pkg::ST_TOMB_VALUE;
          end else if (total > {2'b00, cfg.max_size}) begin
            res_a.status = lrdc_pkg::ST_TOO_LARGE;
          end else begin
            res_a.status = lrdc_pkg::ST_OK;
          end
          if (res_a.status != lrdc_pkg::ST_OK) begin
            num       = 2'd1;
            phase_nxt = eob_r ? PH_HEADER : PH_DISCARD;
          end else if (eob_r) begin
            num          = 2'd1;
            res_a.status = lrdc_pkg::ST_BODY_TRUNC;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        // Forward the byte, then close the record or flag truncation
        crc_nxt            = crc_byte(crc_r, byte_r);
        num                = 2'd1;
        res_a              = res_hdr;
        res_a.kind         = (pos_r < key_r) ? lrdc_pkg::KIND_KEY : lrdc_pkg::KIND_VALUE;
        res_a.payload_byte = byte_r;
        pos_nxt            = pos_inc[31:0];
        res_b              = res_hdr;
        res_b.kind         = lrdc_pkg::KIND_STATUS;
        // Compare the wrapped 32-bit position against the body length
        if ({1'b0, pos_inc[31:0]} >= body_len) begin
          num          = 2'd2;
          res_b.status = ((crc_nxt ^ lrdc_pkg::CRC_INIT) == scrc_r) ?
                         lrdc_pkg::ST_OK : lrdc_pkg::ST_CRC_BAD;
          phase_nxt    = PH_HEADER;
          pos_nxt      = '0;
        end else if (eob_r) begin
          num          = 2'd2;
          res_b.status = lrdc_pkg::ST_BODY_TRUNC;
          phase_nxt    = PH_HEADER;
          pos_nxt      = '0;
        end
      end
      default: begin
        // Drop bytes until the buffer ends
        if (eob_r) begin
          phase_nxt = PH_HEADER;
          pos_nxt   = '0;
        end
      end
    endcase

    // Mark the final result of this byte
    if (num == 2'd1) begin
      res_a.last = 1'b1;
    end
    if (num == 2'd2) begin
      res_b.last = 1'b1;
    end
  end

  assign wr.num    = fire ? num : 2'd0;
  assign wr.first  = res_a;
  assign wr.second = res_b;

  // Hold the input transaction and advance record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      scrc_r   <= '0;
      ts_r     <= '0;
      flags_r  <= '0;
      key_r    <= '0;
      val_r    <= '0;
      crc_r    <= lrdc_pkg::CRC_INIT;
    end else begin
      if (in_ready) begin
        hold_v_r <= in_valid;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        scrc_r  <= scrc_nxt;
        ts_r    <= ts_nxt;
        flags_r <= flags_nxt;
        key_r   <= key_nxt;
        val_r   <= val_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eob_r  <= in_end_of_buffer;
    end
  end

  a_hdr_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> pos_r < 32'(lrdc_pkg::HDR_LEN))
    else $error("header position past header length");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr.num == 2'd2 |-> (wr.first.kind != lrdc_pkg::KIND_STATUS) &&
                       (wr.second.kind == lrdc_pkg::KIND_STATUS))
    else $error("two results must be a data byte followed by a status");

  a_eob_resync: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eob_r |=> phase_r == PH_HEADER && pos_r == '0)
    else $error("end of buffer did not return to header phase");

endmodule

`default_nettype wire

@@ rtl/core/lrdc_resq.sv @@
// Result queue: takes up to two results per cycle, delivers one per transaction.
`default_nettype none

module lrdc_resq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lrdc_pkg::resq_wr_t wr,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lrdc_pkg::result_t       head
);

  lrdc_pkg::result_t           ent_r [lrdc_pkg::QDEPTH];
  logic [lrdc_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [lrdc_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [lrdc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= lrdc_pkg::QCNT_W'(lrdc_pkg::QDEPTH - 2));
  assign head      = ent_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + lrdc_pkg::QCNT_W'(wr.num) - lrdc_pkg::QCNT_W'(pop);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + lrdc_pkg::QPTR_W'(wr.num);
      rd_ptr_r <= rd_ptr_r + lrdc_pkg::QPTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (wr.num != 2'd0) begin
      ent_r[wr_ptr_r] <= wr.first;
    end
    if (wr.num == 2'd2) begin
      ent_r[wr_ptr_r + lrdc_pkg::QPTR_W'(1)] <= wr.second;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lrdc_pkg::QCNT_W'(lrdc_pkg::QDEPTH))
    else $error("result queue overflow");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("empty queue with pointers apart");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.num != 2'd0 |-> cnt_r <= lrdc_pkg::QCNT_W'(lrdc_pkg::QDEPTH - 2))
    else $error("push without room for two results");

endmodule

`default_nettype wire

@@ rtl/core/log_record_decoder_checker.sv @@
// Log record decoder and checker: one byte per transaction, CRC-32 checked records.
// Each accepted byte is held in the input register; its results are written to the
// result queue and offered from there. Throughput: one byte per cycle while the queue
// has room for two results; a byte that closes a record gives two results, and the
// one-result-per-cycle output port paces those.
// Reset (rst_n low, synchronous): header phase, counters and result queue cleared,
// registers back to defaults; no clearing pass, input ready once reset is released.
`default_nettype none

module log_record_decoder_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input byte stream
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_end_of_buffer,
  // Results
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [1:0]                  out_kind,
  output logic      [7:0]                  out_payload_byte,
  output logic      [2:0]                  out_status,
  output logic      [63:0]                 out_timestamp,
  output logic                             out_tombstone,
  output logic      [31:0]                 out_key_length,
  output logic      [31:0]                 out_value_length,
  output logic      [33:0]                 out_record_size,
  output logic                             out_last,
  // Configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lrdc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  lrdc_pkg::cfg_t     cfg;
  lrdc_pkg::resq_wr_t wr;
  lrdc_pkg::result_t  head;
  logic               room;

  lrdc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrdc_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .cfg              (cfg),
    .room             (room),
    .wr               (wr)
  );

  lrdc_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Unpack the queue head onto the result ports
  assign out_kind         = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_status       = head.status;
  assign out_timestamp    = head.timestamp;
  assign out_tombstone    = head.tombstone;
  assign out_key_length   = head.key_length;
  assign out_value_length = head.value_length;
  assign out_record_size  = head.record_size;
  assign out_last         = head.last;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the log record decoder and checker.
`timescale 1ns / 1ps

module tb_top;
  import lrdc_pkg::*;

  // Decoder phases, mirrored in the expected-result model
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_DISCARD = 2'd2
  } rec_phase_e;

  // One directed record: configuration it runs under, header fields and how it is cut
  typedef struct {
    logic [31:0] max_size;
    logic [7:0]  mask;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic [7:0]  flags;
    logic [63:0] ts;
    int          fill;
    int          cut;
    bit          bad_crc;
    bit          eob;
    int          want;
  } rec_case_t;

  localparam int NUM_DIR         = 22;
  localparam int WHOLE           = -1;
  localparam int RANDOM_FILL     = -1;
  localparam int NO_STATUS       = -1;
  localparam int DRAIN_CYCLES    = 8;
  localparam int BYTES_PER_PHASE = 250;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_PRINTS      = 20;

  localparam logic [CFG_AW-1:0] ADDR_MAX_SIZE  = CFG_AW'(int'(REG_MAX_SIZE) << REG_IDX_LSB);
  localparam logic [CFG_AW-1:0] ADDR_TOMB_MASK = CFG_AW'(int'(REG_TOMB_MASK) << REG_IDX_LSB);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_end_of_buffer = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [7:0]        out_payload_byte;
  logic [2:0]        out_status;
  logic [63:0]       out_timestamp;
  logic              out_tombstone;
  logic [31:0]       out_key_length;
  logic [31:0]       out_value_length;
  logic [33:0]       out_record_size;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  // Expected-result model state
  rec_phase_e  rec_phase = PH_HEADER;
  logic [31:0] hdr_pos = 32'd0;
  logic [31:0] rec_crc = 32'd0;
  logic [63:0] rec_timestamp = 64'd0;
  logic [7:0]  rec_flags = 8'd0;
  logic [31:0] rec_key_len = 32'd0;
  logic [31:0] rec_val_len = 32'd0;
  logic [31:0] crc_acc = CRC_INIT;
  logic [31:0] cfg_max_size = MAX_SIZE_RST;
  logic [7:0]  cfg_tomb_mask = TOMB_MASK_RST;

  result_t     record_results_q [$];
  int          last_status_pred = NO_STATUS;
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          status_seen [8] = '{default: 0};
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          gap_plan [4] = '{0, 45, 0, 7};
  int          stall_plan [4] = '{0, 0, 45, 7};
  rec_case_t   dir_cases [NUM_DIR];

  log_record_decoder_checker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_timestamp    (out_timestamp),
    .out_tombstone    (out_tombstone),
    .out_key_length   (out_key_length),
    .out_value_length (out_value_length),
    .out_record_size  (out_record_size),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] run stopped after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [33:0] record_total();
    return 34'(HDR_LEN) + 34'(rec_key_len) + 34'(rec_val_len);
  endfunction

  // Build one result from the header fields held for the current record
  function automatic result_t make_result(logic [1:0] kind, logic [7:0] pb, logic [2:0] st,
                                          bit with_hdr);
    result_t r;
    r = '0;
    r.kind = kind;
    r.payload_byte = pb;
    r.status = st;
    if (with_hdr) begin
      r.timestamp = rec_timestamp;
      r.tombstone = |(rec_flags & cfg_tomb_mask);
      r.key_length = rec_key_len;
      r.value_length = rec_val_len;
      r.record_size = record_total();
    end
    return r;
  endfunction

  // Advance the record decoder by one byte and queue the results it gives
  function automatic void decode_byte(logic [7:0] b, logic eob);
    result_t    res [2];
    int         n;
    logic [2:0] err;
    n = 0;
    err = ST_OK;
    case (rec_phase)
      PH_HEADER: begin
        if (hdr_pos == 0) begin
          rec_crc = 32'd0;
          rec_timestamp = 64'd0;
          rec_flags = 8'd0;
          rec_key_len = 32'd0;
          rec_val_len = 32'd0;
          crc_acc = CRC_INIT;
        end
        if (hdr_pos >= TS_POS)
          crc_acc = crc32_step(crc_acc, b);
        if (hdr_pos < TS_POS)
          rec_crc = rec_crc | (32'(b) << (8 * hdr_pos));
        else if (hdr_pos < FLAGS_POS)
          rec_timestamp = rec_timestamp | (64'(b) << (8 * (hdr_pos - TS_POS)));
        else if (hdr_pos == FLAGS_POS)
          rec_flags = b;
        else if (hdr_pos < VAL_POS)
          rec_key_len = rec_key_len | (32'(b) << (8 * (hdr_pos - KEY_POS)));
        else if (hdr_pos < HDR_LEN)
          rec_val_len = rec_val_len | (32'(b) << (8 * (hdr_pos - VAL_POS)));
        hdr_pos++;
        if (hdr_pos < HDR_LEN) begin
          if (eob) begin
            res[n] = make_result(KIND_STATUS, 8'd0, ST_HDR_TRUNC, 1'b0);
            n++;
            hdr_pos = 0;
          end
        end else begin
          // Header checks in priority order
          if (rec_key_len == 0)
            err = ST_ZERO_KEY;
          else if ((rec_flags & cfg_tomb_mask) != 0 && rec_val_len != 0)
            err = ST_TOMB_VALUE;
          else if (record_total() > 34'(cfg_max_size))
            err = ST_TOO_LARGE;
          hdr_pos = 0;
          if (err != ST_OK) begin
            res[n] = make_result(KIND_STATUS, 8'd0, err, 1'b1);
            n++;
            rec_phase = eob ? PH_HEADER : PH_DISCARD;
          end else if (eob) begin
            res[n] = make_result(KIND_STATUS, 8'd0, ST_BODY_TRUNC, 1'b1);
            n++;
          end else begin
            rec_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_acc = crc32_step(crc_acc, b);
        res[n] = make_result(hdr_pos < rec_key_len ? KIND_KEY : KIND_VALUE, b, ST_OK, 1'b1);
        n++;
        hdr_pos++;
        if (34'(hdr_pos) >= 34'(rec_key_len) + 34'(rec_val_len)) begin
          res[n] = make_result(KIND_STATUS, 8'd0,
                               ((crc_acc ^ CRC_INIT) == rec_crc) ? ST_OK : ST_CRC_BAD, 1'b1);
          n++;
          rec_phase = PH_HEADER;
          hdr_pos = 0;
        end else if (eob) begin
          res[n] = make_result(KIND_STATUS, 8'd0, ST_BODY_TRUNC, 1'b1);
          n++;
          rec_phase = PH_HEADER;
          hdr_pos = 0;
        end
      end
      default: begin
        // Drop bytes until the buffer ends
        if (eob) begin
          rec_phase = PH_HEADER;
          hdr_pos = 0;
        end
      end
    endcase
    if (n > 0)
      res[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (res[i].kind == KIND_STATUS)
        last_status_pred = int'(res[i].status);
      record_results_q.push_back(res[i]);
    end
  endfunction

  // Compare one accepted result with the oldest expected one
  task automatic check_result(input result_t got);
    result_t want;
    if (record_results_q.size() == 0) begin
      report_mismatch("result with none expected, kind", 64'(got.kind), 64'd0);
      return;
    end
    want = record_results_q.pop_front();
    if (got.kind != want.kind)
      report_mismatch("kind", 64'(got.kind), 64'(want.kind));
    if (got.payload_byte != want.payload_byte)
      report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
    if (got.status != want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.timestamp != want.timestamp)
      report_mismatch("timestamp", got.timestamp, want.timestamp);
    if (got.tombstone != want.tombstone)
      report_mismatch("tombstone", 64'(got.tombstone), 64'(want.tombstone));
    if (got.key_length != want.key_length)
      report_mismatch("key_length", 64'(got.key_length), 64'(want.key_length));
    if (got.value_length != want.value_length)
      report_mismatch("value_length", 64'(got.value_length), 64'(want.value_length));
    if (got.record_size != want.record_size)
      report_mismatch("record_size", 64'(got.record_size), 64'(want.record_size));
    if (got.last != want.last)
      report_mismatch("last", 64'(got.last), 64'(want.last));
  endtask

  // Sample each result transaction
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind = out_kind;
      got.payload_byte = out_payload_byte;
      got.status = out_status;
      got.timestamp = out_timestamp;
      got.tombstone = out_tombstone;
      got.key_length = out_key_length;
      got.value_length = out_value_length;
      got.record_size = out_record_size;
      got.last = out_last;
      results_seen++;
      if (got.kind == KIND_STATUS)
        status_seen[got.status]++;
      check_result(got);
    end
  end

  // Offer one byte, idle first at random, and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    decode_byte(b, eob);
    bytes_sent++;
  endtask

  // Send a record with a valid or corrupted CRC, cut after `cut` bytes when asked
  task automatic send_record(input logic [31:0] key_len, input logic [31:0] val_len,
                             input logic [7:0] flags, input logic [63:0] ts, input int fill,
                             input int cut, input bit bad_crc, input bit eob_last);
    logic [7:0]  frame [$];
    longint      n;
    logic [31:0] crc;
    n = (cut < 0) ? (longint'(HDR_LEN) + longint'(key_len) + longint'(val_len)) : cut;
    frame = {};
    for (int i = 0; i < 4; i++)
      frame.push_back(8'h00);
    for (int i = 0; i < 8; i++)
      frame.push_back(ts[8*i +: 8]);
    frame.push_back(flags);
    for (int i = 0; i < 4; i++)
      frame.push_back(key_len[8*i +: 8]);
    for (int i = 0; i < 4; i++)
      frame.push_back(val_len[8*i +: 8]);
    for (longint i = HDR_LEN; i < n; i++)
      frame.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    crc = CRC_INIT;
    for (int i = 4; i < frame.size(); i++)
      crc = crc32_step(crc, frame[i]);
    crc = crc ^ CRC_INIT ^ {31'd0, bad_crc};
    for (int i = 0; i < 4; i++)
      frame[i] = crc[8*i +: 8];
    for (longint i = 0; i < n; i++)
      push_byte(frame[i], eob_last && (i == n - 1));
  endtask

  // Raw bytes ending a buffer
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++)
      push_byte(8'($urandom), i == count - 1);
  endtask

  task automatic send_random_record();
    logic [31:0] k;
    logic [31:0] v;
    logic [7:0]  f;
    longint      total;
    int          cut;
    bit          hdr_bad;
    bit          eob;
    if ($urandom_range(99) < 6) begin
      send_noise($urandom_range(1, 30));
      return;
    end
    k = ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
    v = 32'($urandom_range(0, 8));
    if ($urandom_range(24) == 0)
      k = $urandom;
    if ($urandom_range(24) == 0)
      v = $urandom;
    f = 8'($urandom);
    if ($urandom_range(3) != 0)
      f = f & ~cfg_tomb_mask;
    total = longint'(HDR_LEN) + longint'(k) + longint'(v);
    hdr_bad = (k == 0) || ((f & cfg_tomb_mask) != 0 && v != 0) ||
              (total > longint'(cfg_max_size));
    cut = WHOLE;
    eob = ($urandom_range(2) == 0);
    // Cut long or broken records short; a bad header mostly ends its buffer soon
    if (hdr_bad) begin
      cut = int'(HDR_LEN) + $urandom_range(0, 5);
      eob = ($urandom_range(7) != 0);
    end else if (total > 64 || $urandom_range(6) == 0) begin
      cut = $urandom_range(1, (total > 64) ? 64 : int'(total));
      eob = 1'b1;
    end
    send_record(k, v, f, {$urandom, $urandom}, RANDOM_FILL, cut, $urandom_range(9) == 0, eob);
  endtask

  // Stop sending and let every expected result come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (record_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Read a register back and check it against the expected value
  task automatic check_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] want,
                           input logic [31:0] keep);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if ((prdata & keep) != (want & keep))
      report_mismatch("register readback", 64'(prdata & keep), 64'(want & keep));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, mirror it in the model, then read it back
  task automatic program_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data,
                             input logic [31:0] keep);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if (addr == ADDR_MAX_SIZE)
      cfg_max_size = data;
    else
      cfg_tomb_mask = data[7:0];
    check_reg(addr, data, keep);
  endtask

  task automatic apply_config(input logic [31:0] max_size, input logic [7:0] mask);
    drain_results();
    program_reg(ADDR_MAX_SIZE, max_size, 32'hFFFF_FFFF);
    program_reg(ADDR_TOMB_MASK, {24'd0, mask}, 32'h0000_00FF);
  endtask

  initial begin
    rec_case_t c;
    int        phase_start;
    bit        paused;

    // max, mask, key, value, flags, timestamp, fill, cut, bad crc, eob, status
    dir_cases = '{
      // smallest record, all-zero bytes
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd1, 32'd0, 8'h00, 64'h0,
        8'h00, WHOLE, 1'b0, 1'b1, NO_STATUS},
      // all-ones bytes, flags without the tombstone bit
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd3, 32'd4, 8'hFE, 64'hFFFF_FFFF_FFFF_FFFF,
        8'hFF, WHOLE, 1'b0, 1'b0, NO_STATUS},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd2, 32'd2, 8'h00, 64'h0123_4567_89AB_CDEF,
        RANDOM_FILL, WHOLE, 1'b1, 1'b0, ST_CRC_BAD},
      // zero key, buffer ends on the erroring byte
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd0, 32'd5, 8'h00, 64'h11,
        RANDOM_FILL, 21, 1'b0, 1'b1, ST_ZERO_KEY},
      // zero key with the tombstone flag set; trailing bytes dropped
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd0, 32'd0, 8'h01, 64'h22,
        RANDOM_FILL, 25, 1'b0, 1'b1, ST_ZERO_KEY},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd2, 32'd3, 8'h01, 64'h33,
        RANDOM_FILL, 23, 1'b0, 1'b1, ST_TOMB_VALUE},
      // tombstone without a value is fine
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd2, 32'd0, 8'h01, 64'h44,
        RANDOM_FILL, WHOLE, 1'b0, 1'b0, NO_STATUS},
      // tombstone wins over size
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd1, 32'h00FF_FFFF, 8'h01, 64'h55,
        RANDOM_FILL, 21, 1'b0, 1'b1, ST_TOMB_VALUE},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'h00FF_FFFF, 32'd0, 8'h00, 64'h66,
        RANDOM_FILL, 22, 1'b0, 1'b1, ST_TOO_LARGE},
      // size equal to the limit passes; buffer ends on the final header byte
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'h00FF_FFEB, 32'd0, 8'h00, 64'h77,
        RANDOM_FILL, 21, 1'b0, 1'b1, ST_BODY_TRUNC},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd4, 32'd4, 8'h00, 64'h88,
        RANDOM_FILL, 10, 1'b0, 1'b1, ST_HDR_TRUNC},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd4, 32'd4, 8'h00, 64'h99,
        RANDOM_FILL, 1, 1'b0, 1'b1, ST_HDR_TRUNC},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd3, 32'd3, 8'h00, 64'hAA,
        RANDOM_FILL, 20, 1'b0, 1'b1, ST_HDR_TRUNC},
      // buffer ends inside the key
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd4, 32'd4, 8'h00, 64'hBB,
        RANDOM_FILL, 25, 1'b0, 1'b1, ST_BODY_TRUNC},
      // buffer ends exactly on the last body byte
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'd2, 32'd3, 8'h00, 64'hCC,
        RANDOM_FILL, WHOLE, 1'b0, 1'b1, NO_STATUS},
      '{MAX_SIZE_RST, TOMB_MASK_RST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 64'hDD,
        RANDOM_FILL, 30, 1'b0, 1'b1, ST_TOO_LARGE},
      // widest limit, every flag bit marks a tombstone
      '{32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 64'hEE,
        RANDOM_FILL, 21, 1'b0, 1'b1, ST_TOO_LARGE},
      '{32'hFFFF_FFFF, 8'hFF, 32'd5, 32'd2, 8'h40, 64'hF0,
        RANDOM_FILL, 22, 1'b0, 1'b1, ST_TOMB_VALUE},
      '{32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFF0, 32'h0000_000F, 8'h00, 64'hF1,
        RANDOM_FILL, 24, 1'b0, 1'b1, ST_BODY_TRUNC},
      // smallest limit rejects every record
      '{32'd21, 8'h80, 32'd1, 32'd0, 8'h7F, 64'hF2,
        RANDOM_FILL, 21, 1'b0, 1'b1, ST_TOO_LARGE},
      // zero mask: no tombstones at all
      '{32'd22, 8'h00, 32'd1, 32'd0, 8'hFF, 64'hF3,
        RANDOM_FILL, WHOLE, 1'b0, 1'b0, NO_STATUS},
      '{32'hFFFF_FFFF, 8'h00, 32'd2, 32'd5, 8'hFF, 64'hF4,
        RANDOM_FILL, WHOLE, 1'b0, 1'b1, NO_STATUS}
    };

    // Hold reset, then confirm register defaults
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(ADDR_MAX_SIZE, MAX_SIZE_RST, 32'hFFFF_FFFF);
    check_reg(ADDR_TOMB_MASK, {24'd0, TOMB_MASK_RST}, 32'h0000_00FF);

    // Directed records
    foreach (dir_cases[i]) begin
      c = dir_cases[i];
      if (c.max_size != cfg_max_size || c.mask != cfg_tomb_mask)
        apply_config(c.max_size, c.mask);
      last_status_pred = NO_STATUS;
      send_record(c.key_len, c.val_len, c.flags, c.ts, c.fill, c.cut, c.bad_crc, c.eob);
      if (c.want != NO_STATUS && c.want != last_status_pred)
        report_mismatch("directed record status", 64'(last_status_pred), 64'(c.want));
    end

    // Random traffic under several settings and idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: apply_config(MAX_SIZE_RST, TOMB_MASK_RST);
        1: apply_config(32'd40, 8'h81);
        2: apply_config(32'hFFFF_FFFF, 8'hFF);
        default: apply_config(32'($urandom_range(22, 60)), 8'($urandom_range(1, 255)));
      endcase
      gap_pct = gap_plan[ph];
      stall_pct = stall_plan[ph];
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        send_random_record();
        // hold the input once until the output side catches up
        if (!paused && bytes_sent - phase_start > BYTES_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    gap_pct = 0;
    drain_results();
    if (record_results_q.size() != 0)
      report_mismatch("results never produced", 64'(record_results_q.size()), 64'd0);

    $display("Sent %0d bytes (directed records, then 4 idle mixes and settings), %0d results",
             bytes_sent, results_seen);
    $display("Status: ok %0d, hdr cut %0d, zero key %0d, tomb value %0d, too large %0d, %s",
             status_seen[ST_OK], status_seen[ST_HDR_TRUNC], status_seen[ST_ZERO_KEY],
             status_seen[ST_TOMB_VALUE], status_seen[ST_TOO_LARGE],
             $sformatf("body cut %0d, crc bad %0d", status_seen[ST_BODY_TRUNC],
                       status_seen[ST_CRC_BAD]));
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lrdc_pkg.sv
rtl/core/lrdc_cfg.sv
rtl/core/lrdc_parser.sv
rtl/core/lrdc_resq.sv
rtl/core/log_record_decoder_checker.sv
tb/sv/tb_top.sv
